// File: hdl/spectral_growth_arm_release_detector_top_macros.svh
// Assertion macros used by the detector's back end.
`ifndef SPECTRAL_GROWTH_ARM_RELEASE_DETECTOR_TOP_MACROS_SVH
`define SPECTRAL_GROWTH_ARM_RELEASE_DETECTOR_TOP_MACROS_SVH

// Checked only while reset is released.
`define SGARD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sgard: assertion failed");

// Checked at every edge, reset included.
`define SGARD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sgard: reset assertion failed");

`endif

// File: hdl/sgard_pkg.sv
// Types and constants shared by the spectral growth detector.
package sgard_pkg;

    typedef struct packed {
        logic [14:0]        prominence_threshold;
        logic signed [15:0] arm_growth_threshold;
        logic [14:0]        release_margin;
        logic signed [15:0] silence_floor;
        logic [3:0]         arm_hold_count;
        logic [3:0]         release_hold_count;
        logic [8:0]         smoothing_weight;
    } cfg_t;

    localparam logic [2:0] REG_PROMINENCE = 3'd0;
    localparam logic [2:0] REG_ARM_GROWTH = 3'd1;
    localparam logic [2:0] REG_RELEASE    = 3'd2;
    localparam logic [2:0] REG_FLOOR      = 3'd3;
    localparam logic [2:0] REG_ARM_HOLD   = 3'd4;
    localparam logic [2:0] REG_REL_HOLD   = 3'd5;
    localparam logic [2:0] REG_WEIGHT     = 3'd6;

    localparam logic [14:0]        RST_PROMINENCE = 15'd3200;
    localparam logic signed [15:0] RST_ARM_GROWTH = 16'sd102;
    localparam logic [14:0]        RST_RELEASE    = 15'd1280;
    localparam logic signed [15:0] RST_FLOOR      = -16'sd10240;
    localparam logic [3:0]         RST_ARM_HOLD   = 4'd2;
    localparam logic [3:0]         RST_REL_HOLD   = 4'd8;
    localparam logic [8:0]         RST_WEIGHT     = 9'd154;

    localparam logic signed [15:0] LEVEL_RESET = -16'sd25600;
    localparam logic [3:0]         COUNT_MAX   = 4'd15;
    localparam logic [8:0]         WEIGHT_ONE  = 9'd256;

    typedef struct packed {
        logic signed [15:0] level;
        logic               peak;
        logic               last;
    } job_t;

    typedef struct packed {
        logic signed [15:0] prev;
        logic signed [15:0] growth;
        logic [3:0]         qcount;
        logic               armed;
        logic signed [15:0] peak;
        logic [3:0]         below;
    } rec_t;

    typedef struct packed {
        logic [10:0]        bin_number;
        logic signed [15:0] growth_now;
        logic               bin_armed;
        logic               armed_event;
        logic               released_event;
        logic [10:0]        armed_bins;
        logic [31:0]        arm_total;
        logic [31:0]        release_total;
        logic               last_of_frame;
    } result_t;

endpackage

// File: hdl/spectral_growth_arm_release_detector_top.sv
// Top level of the spectral growth arm/release detector.
// A bin's result reaches the result ports through the job queue, stages b and c and the result queue.
// Inside a frame one item is taken per cycle while the job queue has room; a frame of L bins
// ends by flushing min(L, 2*SHOULDER_OFFSET) bins, one per cycle while there is room, input held.
// The memory serves one bin per cycle unless stalled; a job waits while its bin is in stage b or c.
// After reset a clearing pass over all NUM_BINS state entries runs before the first item is taken.
module spectral_growth_arm_release_detector_top #(
    parameter int NUM_BINS = 1025,
    parameter int SHOULDER_OFFSET = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] level_db,
    input  logic               frame_end,
    output logic               empty,
    input  logic               pop,
    output logic [10:0]        bin_number,
    output logic signed [15:0] growth_now,
    output logic               bin_armed,
    output logic               armed_event,
    output logic               released_event,
    output logic [10:0]        armed_bins,
    output logic [31:0]        arm_total,
    output logic [31:0]        release_total,
    output logic               last_of_frame,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int JQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;
    localparam int JQ_W     = BIN_W + $bits(sgard_pkg::job_t);
    localparam int RES_W    = $bits(sgard_pkg::result_t);
    localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    sgard_pkg::cfg_t cfg_reg, cfg_next;

    logic                job_push;
    logic [BIN_W-1:0]    job_bin_in;
    sgard_pkg::job_t     job_info_in;
    logic [JQ_W-1:0]     jq_rd_data;
    logic [JQ_CNT_W-1:0] jq_count;
    logic                jq_pop;
    logic                job_room;
    logic                clearing;
    logic                res_push;
    sgard_pkg::result_t  res_in;
    logic [RES_W-1:0]    oq_rd_data;
    sgard_pkg::result_t  res_out;
    logic [OQ_CNT_W-1:0] oq_count;
    logic                oq_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sgard_pkg::REG_PROMINENCE: cfg_next.prominence_threshold = cfg_data[14:0];
                sgard_pkg::REG_ARM_GROWTH: cfg_next.arm_growth_threshold = $signed(cfg_data);
                sgard_pkg::REG_RELEASE:    cfg_next.release_margin       = cfg_data[14:0];
                sgard_pkg::REG_FLOOR:      cfg_next.silence_floor        = $signed(cfg_data);
                sgard_pkg::REG_ARM_HOLD:   cfg_next.arm_hold_count       = cfg_data[3:0];
                sgard_pkg::REG_REL_HOLD:   cfg_next.release_hold_count   = cfg_data[3:0];
                sgard_pkg::REG_WEIGHT:     cfg_next.smoothing_weight     = cfg_data[8:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prominence_threshold <= sgard_pkg::RST_PROMINENCE;
            cfg_reg.arm_growth_threshold <= sgard_pkg::RST_ARM_GROWTH;
            cfg_reg.release_margin       <= sgard_pkg::RST_RELEASE;
            cfg_reg.silence_floor        <= sgard_pkg::RST_FLOOR;
            cfg_reg.arm_hold_count       <= sgard_pkg::RST_ARM_HOLD;
            cfg_reg.release_hold_count   <= sgard_pkg::RST_REL_HOLD;
            cfg_reg.smoothing_weight     <= sgard_pkg::RST_WEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign job_room = jq_count < JQ_CNT_W'(JQ_DEPTH);

    sgard_front #(
        .NUM_BINS        (NUM_BINS),
        .SHOULDER_OFFSET (SHOULDER_OFFSET)
    ) u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .level_db             (level_db),
        .frame_end            (frame_end),
        .prominence_threshold (cfg_reg.prominence_threshold),
        .hold                 (clearing),
        .job_room             (job_room),
        .full                 (full),
        .job_push             (job_push),
        .job_bin              (job_bin_in),
        .job_info             (job_info_in)
    );

    sgard_fifo #(
        .WIDTH (JQ_W),
        .DEPTH (JQ_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data ({job_bin_in, job_info_in}),
        .rd_en   (jq_pop),
        .rd_data (jq_rd_data),
        .count   (jq_count)
    );

    sgard_back #(
        .NUM_BINS (NUM_BINS),
        .OQ_DEPTH (OQ_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .jq_empty (jq_count == '0),
        .job_bin  (jq_rd_data[JQ_W-1 -: BIN_W]),
        .job_info (sgard_pkg::job_t'(jq_rd_data[$bits(sgard_pkg::job_t)-1:0])),
        .oq_count (oq_count),
        .jq_pop   (jq_pop),
        .clearing (clearing),
        .res_push (res_push),
        .res_data (res_in)
    );

    assign empty  = (oq_count == '0);
    assign oq_pop = pop && !empty;

    sgard_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OQ_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (oq_pop),
        .rd_data (oq_rd_data),
        .count   (oq_count)
    );

    assign res_out        = sgard_pkg::result_t'(oq_rd_data);
    assign bin_number     = res_out.bin_number;
    assign growth_now     = res_out.growth_now;
    assign bin_armed      = res_out.bin_armed;
    assign armed_event    = res_out.armed_event;
    assign released_event = res_out.released_event;
    assign armed_bins     = res_out.armed_bins;
    assign arm_total      = res_out.arm_total;
    assign release_total  = res_out.release_total;
    assign last_of_frame  = res_out.last_of_frame;

endmodule

// File: hdl/sgard_fifo.sv
// Small first-in first-out queue built from registers.
module sgard_fifo #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

// File: hdl/sgard_front.sv
// Front end: lookahead window, peak test and generation of per-bin jobs.
module sgard_front #(
    parameter int NUM_BINS = 1025,
    parameter int SHOULDER_OFFSET = 4,
    localparam int BIN_W = $clog2(NUM_BINS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic signed [15:0] level_db,
    input  logic               frame_end,
    input  logic [14:0]        prominence_threshold,
    input  logic               hold,
    input  logic               job_room,
    output logic               full,
    output logic               job_push,
    output logic [BIN_W-1:0]   job_bin,
    output sgard_pkg::job_t    job_info
);

    localparam int OFS       = SHOULDER_OFFSET;
    localparam int WIN_LEN   = 4 * OFS + 1;
    localparam int BACK_W    = $clog2(2 * OFS) > 0 ? $clog2(2 * OFS) : 1;
    localparam int WIN_IDX_W = $clog2(WIN_LEN);

    logic signed [15:0] win_reg [WIN_LEN];
    logic signed [15:0] win_next [WIN_LEN];
    logic [BIN_W-1:0]   bin_cnt_reg, bin_cnt_next;
    logic               flush_reg, flush_next;
    logic [BIN_W-1:0]   flush_bin_reg, flush_bin_next;
    logic [BACK_W-1:0]  flush_back_reg, flush_back_next;

    logic                 accept;
    logic                 end_item;
    logic                 has_look;
    logic                 peak_ok;
    logic                 peak_test;
    logic signed [16:0]   l2;
    logic signed [16:0]   r2;
    logic signed [16:0]   sh;
    logic signed [18:0]   diff;
    logic signed [18:0]   thr2;
    logic [WIN_IDX_W-1:0] win_idx;

    assign full   = hold || flush_reg || !job_room;
    assign accept = push && !full;

    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WIN_LEN-1] = level_db;
    end

    assign end_item = frame_end || (bin_cnt_reg == BIN_W'(NUM_BINS - 1));
    assign has_look = bin_cnt_reg >= BIN_W'(2 * OFS);
    assign peak_ok  = bin_cnt_reg >= BIN_W'(4 * OFS);

    always_comb
    begin
        l2   = 17'(win_next[OFS]) + 17'(win_next[0]);
        r2   = 17'(win_next[3*OFS]) + 17'(win_next[4*OFS]);
        sh   = (l2 > r2) ? l2 : r2;
        diff = 19'($signed({win_next[2*OFS], 1'b0})) - 19'(sh);
        thr2 = $signed({3'b000, prominence_threshold, 1'b0});
        peak_test = peak_ok
            && !(win_next[2*OFS] < win_next[2*OFS-1])
            && !(win_next[2*OFS] < win_next[2*OFS+1])
            && (diff >= thr2);
    end

    assign win_idx = WIN_IDX_W'(WIN_LEN - 1) - WIN_IDX_W'(flush_back_reg);

    always_comb
    begin
        job_push       = 1'b0;
        job_bin        = flush_bin_reg;
        job_info.level = win_reg[win_idx];
        job_info.peak  = 1'b0;
        job_info.last  = (flush_back_reg == '0);
        if (accept && has_look)
        begin
            job_push       = 1'b1;
            job_bin        = bin_cnt_reg - BIN_W'(2 * OFS);
            job_info.level = win_next[2*OFS];
            job_info.peak  = peak_test;
            job_info.last  = 1'b0;
        end
        else if (flush_reg && job_room)
        begin
            job_push = 1'b1;
        end
    end

    always_comb
    begin
        bin_cnt_next    = bin_cnt_reg;
        flush_next      = flush_reg;
        flush_bin_next  = flush_bin_reg;
        flush_back_next = flush_back_reg;
        if (accept)
        begin
            if (end_item)
            begin
                bin_cnt_next = '0;
                flush_next   = 1'b1;
                if (has_look)
                begin
                    flush_bin_next  = bin_cnt_reg - BIN_W'(2 * OFS - 1);
                    flush_back_next = BACK_W'(2 * OFS - 1);
                end
                else
                begin
                    flush_bin_next  = '0;
                    flush_back_next = BACK_W'(bin_cnt_reg);
                end
            end
            else
            begin
                bin_cnt_next = bin_cnt_reg + BIN_W'(1);
            end
        end
        else if (flush_reg && job_room)
        begin
            if (flush_back_reg == '0)
            begin
                flush_next = 1'b0;
            end
            else
            begin
                flush_back_next = flush_back_reg - BACK_W'(1);
                flush_bin_next  = flush_bin_reg + BIN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg    <= '0;
            flush_reg      <= 1'b0;
            flush_bin_reg  <= '0;
            flush_back_reg <= '0;
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            bin_cnt_reg    <= bin_cnt_next;
            flush_reg      <= flush_next;
            flush_bin_reg  <= flush_bin_next;
            flush_back_reg <= flush_back_next;
            if (accept)
            begin
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

endmodule

// File: hdl/sgard_back.sv
// Back end: per-bin state memory, growth smoothing and arm/release logic.
`include "spectral_growth_arm_release_detector_top_macros.svh"

module sgard_back #(
    parameter int NUM_BINS = 1025,
    parameter int OQ_DEPTH = 4,
    localparam int BIN_W = $clog2(NUM_BINS),
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgard_pkg::cfg_t       cfg,
    input  logic                  jq_empty,
    input  logic [BIN_W-1:0]      job_bin,
    input  sgard_pkg::job_t       job_info,
    input  logic [OQ_CNT_W-1:0]   oq_count,
    output logic                  jq_pop,
    output logic                  clearing,
    output logic                  res_push,
    output sgard_pkg::result_t    res_data
);

    localparam int FL_W = OQ_CNT_W + 1;

    sgard_pkg::rec_t mem [NUM_BINS];
    sgard_pkg::rec_t rdata_reg;

    logic             clr_reg, clr_next;
    logic [BIN_W-1:0] clr_addr_reg, clr_addr_next;

    logic             vb_reg;
    logic [BIN_W-1:0] bin_b_reg;
    sgard_pkg::job_t  info_b_reg;

    logic               vc_reg;
    logic [BIN_W-1:0]   bin_c_reg;
    sgard_pkg::job_t    info_c_reg;
    sgard_pkg::rec_t    rec_c_reg;
    logic signed [26:0] p1_reg;
    logic signed [26:0] p2_reg;

    logic [10:0] armed_cnt_reg, armed_cnt_next;
    logic [31:0] arm_tot_reg, arm_tot_next;
    logic [31:0] rel_tot_reg, rel_tot_next;

    logic             issue;
    logic             hazard;
    logic [FL_W-1:0]  inflight;

    logic [8:0]         w;
    logic [8:0]         wc;
    logic signed [16:0] growth;
    logic signed [26:0] p1;
    logic signed [26:0] p2;

    logic signed [27:0] s;
    logic signed [19:0] gq;
    logic signed [15:0] g;
    logic               qual;
    logic [3:0]         qc1;
    logic [3:0]         ahold;
    logic [3:0]         rhold;
    logic signed [16:0] rel_level;
    logic               arm_ev;
    logic               rel_ev;
    sgard_pkg::rec_t    wrec;
    logic               we;
    logic [BIN_W-1:0]   waddr;
    sgard_pkg::rec_t    wdata;

    // The memory is swept to its reset contents once after reset.
    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            if (clr_addr_reg == BIN_W'(NUM_BINS - 1))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + BIN_W'(1);
            end
        end
    end

    assign clearing = clr_reg;

    assign hazard   = (vb_reg && (bin_b_reg == job_bin)) || (vc_reg && (bin_c_reg == job_bin));
    assign inflight = FL_W'(vb_reg) + FL_W'(vc_reg) + FL_W'(oq_count);
    assign issue    = !clr_reg && !jq_empty && !hazard && (inflight < FL_W'(OQ_DEPTH));
    assign jq_pop   = issue;

    always_comb
    begin
        w      = (cfg.smoothing_weight > sgard_pkg::WEIGHT_ONE) ? sgard_pkg::WEIGHT_ONE
                                                                 : cfg.smoothing_weight;
        wc     = sgard_pkg::WEIGHT_ONE - w;
        growth = 17'(info_b_reg.level) - 17'(rdata_reg.prev);
        p1     = 27'($signed({1'b0, w}) * growth);
        p2     = 27'($signed({1'b0, wc}) * rdata_reg.growth);
    end

    always_comb
    begin
        s  = 28'(p1_reg) + 28'(p2_reg) + 28'sd128;
        gq = 20'(s >>> 8);
        if (gq > 20'sd32767)
        begin
            g = 16'sd32767;
        end
        else if (gq < -20'sd32768)
        begin
            g = -16'sd32768;
        end
        else
        begin
            g = 16'(gq);
        end

        qual = info_c_reg.peak && (info_c_reg.level > cfg.silence_floor)
            && (g >= cfg.arm_growth_threshold);
        if (qual)
        begin
            qc1 = (rec_c_reg.qcount == sgard_pkg::COUNT_MAX) ? sgard_pkg::COUNT_MAX
                                                             : rec_c_reg.qcount + 4'd1;
        end
        else
        begin
            qc1 = 4'd0;
        end
        ahold = (cfg.arm_hold_count == 4'd0) ? 4'd1 : cfg.arm_hold_count;
        rhold = (cfg.release_hold_count == 4'd0) ? 4'd1 : cfg.release_hold_count;

        wrec        = rec_c_reg;
        wrec.prev   = info_c_reg.level;
        wrec.growth = g;
        wrec.qcount = qc1;
        arm_ev      = 1'b0;
        rel_ev      = 1'b0;
        rel_level   = '0;
        if (!rec_c_reg.armed && (qc1 >= ahold))
        begin
            wrec.armed = 1'b1;
            wrec.peak  = info_c_reg.level;
            wrec.below = 4'd0;
            arm_ev     = 1'b1;
        end
        else if (rec_c_reg.armed)
        begin
            if (info_c_reg.level > rec_c_reg.peak)
            begin
                wrec.peak = info_c_reg.level;
            end
            rel_level = 17'(wrec.peak) - $signed({2'b00, cfg.release_margin});
            if (17'(info_c_reg.level) <= rel_level)
            begin
                wrec.below = (rec_c_reg.below == sgard_pkg::COUNT_MAX) ? sgard_pkg::COUNT_MAX
                                                                       : rec_c_reg.below + 4'd1;
            end
            else
            begin
                wrec.below = 4'd0;
            end
            if (wrec.below >= rhold)
            begin
                wrec.armed  = 1'b0;
                wrec.qcount = 4'd0;
                rel_ev      = 1'b1;
            end
        end

        armed_cnt_next = armed_cnt_reg;
        arm_tot_next   = arm_tot_reg;
        rel_tot_next   = rel_tot_reg;
        if (vc_reg)
        begin
            armed_cnt_next = armed_cnt_reg + 11'(arm_ev) - 11'(rel_ev);
            arm_tot_next   = arm_tot_reg + 32'(arm_ev);
            rel_tot_next   = rel_tot_reg + 32'(rel_ev);
        end
    end

    always_comb
    begin
        res_push                = vc_reg;
        res_data.bin_number     = 11'(bin_c_reg);
        res_data.growth_now     = g;
        res_data.bin_armed      = wrec.armed;
        res_data.armed_event    = arm_ev;
        res_data.released_event = rel_ev;
        res_data.armed_bins     = armed_cnt_next;
        res_data.arm_total      = arm_tot_next;
        res_data.release_total  = rel_tot_next;
        res_data.last_of_frame  = info_c_reg.last;
    end

    always_comb
    begin
        we    = clr_reg || vc_reg;
        waddr = clr_reg ? clr_addr_reg : bin_c_reg;
        if (clr_reg)
        begin
            wdata.prev   = sgard_pkg::LEVEL_RESET;
            wdata.growth = '0;
            wdata.qcount = '0;
            wdata.armed  = 1'b0;
            wdata.peak   = sgard_pkg::LEVEL_RESET;
            wdata.below  = '0;
        end
        else
        begin
            wdata = wrec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (issue)
        begin
            rdata_reg <= mem[job_bin];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            bin_b_reg  <= job_bin;
            info_b_reg <= job_info;
        end
        if (vb_reg)
        begin
            bin_c_reg  <= bin_b_reg;
            info_c_reg <= info_b_reg;
            rec_c_reg  <= rdata_reg;
            p1_reg     <= p1;
            p2_reg     <= p2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            armed_cnt_reg <= '0;
            arm_tot_reg   <= '0;
            rel_tot_reg   <= '0;
        end
        else
        begin
            clr_reg       <= clr_next;
            clr_addr_reg  <= clr_addr_next;
            vb_reg        <= issue;
            vc_reg        <= vb_reg;
            armed_cnt_reg <= armed_cnt_next;
            arm_tot_reg   <= arm_tot_next;
            rel_tot_reg   <= rel_tot_next;
        end
    end

    `SGARD_ASSERT(a_no_issue_while_clearing, clr_reg |-> !issue)
    `SGARD_ASSERT(a_no_read_before_write, issue |-> !(vc_reg && (bin_c_reg == job_bin)))
    `SGARD_ASSERT(a_events_exclusive, vc_reg |-> !(arm_ev && rel_ev))
    `SGARD_ASSERT(a_result_has_room, vc_reg |-> (oq_count < OQ_CNT_W'(OQ_DEPTH)))
    `SGARD_ASSERT_RST(a_reset_starts_clear, (!rst_n && $past(!rst_n)) |-> (clr_reg && !vb_reg && !vc_reg))

endmodule

// File: tb/growth_detector_checker.sv
// Checker that predicts the detector's per-bin results and compares them with the output channel.
module growth_detector_checker #(
    parameter int NUM_BINS = 1025,
    parameter int SHOULDER_OFFSET = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [15:0] level_db,
    input  logic               frame_end,
    input  logic               empty,
    input  logic               pop,
    input  logic [10:0]        bin_number,
    input  logic signed [15:0] growth_now,
    input  logic               bin_armed,
    input  logic               armed_event,
    input  logic               released_event,
    input  logic [10:0]        armed_bins,
    input  logic [31:0]        arm_total,
    input  logic [31:0]        release_total,
    input  logic               last_of_frame,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 errors,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPAN = 2 * SHOULDER_OFFSET;
    localparam int WIN = 4 * SHOULDER_OFFSET + 1;

    sgard_pkg::cfg_t    cfg;
    logic signed [15:0] prev_level [NUM_BINS];
    logic signed [15:0] growth_mem [NUM_BINS];
    logic [3:0]         qual_cnt [NUM_BINS];
    logic               armed_mem [NUM_BINS];
    logic signed [15:0] peak_mem [NUM_BINS];
    logic [3:0]         below_cnt [NUM_BINS];
    int                 window [WIN];
    int                 bin_pos;
    logic [10:0]        armed_now;
    logic [31:0]        arms_seen;
    logic [31:0]        releases_seen;
    sgard_pkg::result_t results_due [$];

    initial
    begin
        errors = 0;
        outstanding = 0;
        cfg.prominence_threshold = sgard_pkg::RST_PROMINENCE;
        cfg.arm_growth_threshold = sgard_pkg::RST_ARM_GROWTH;
        cfg.release_margin = sgard_pkg::RST_RELEASE;
        cfg.silence_floor = sgard_pkg::RST_FLOOR;
        cfg.arm_hold_count = sgard_pkg::RST_ARM_HOLD;
        cfg.release_hold_count = sgard_pkg::RST_REL_HOLD;
        cfg.smoothing_weight = sgard_pkg::RST_WEIGHT;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            prev_level[i] = sgard_pkg::LEVEL_RESET;
            peak_mem[i] = sgard_pkg::LEVEL_RESET;
            growth_mem[i] = '0;
            qual_cnt[i] = '0;
            armed_mem[i] = 1'b0;
            below_cnt[i] = '0;
        end
        for (int i = 0; i < WIN; i++)
            window[i] = 0;
        bin_pos = 0;
        armed_now = '0;
        arms_seen = '0;
        releases_seen = '0;
    end

    function automatic int level_at(int n, int k);
        int back;
        back = n - k;
        if (back < 0 || back > WIN - 1)
            return 0;
        return window[WIN - 1 - back];
    endfunction

    function automatic bit peak_found(int c, int n);
        int v, left, right, shoulder;
        if (c < SPAN)
            return 1'b0;
        v = level_at(n, c);
        if (v < level_at(n, c - 1) || v < level_at(n, c + 1))
            return 1'b0;
        left = level_at(n, c - SHOULDER_OFFSET) + level_at(n, c - SPAN);
        right = level_at(n, c + SHOULDER_OFFSET) + level_at(n, c + SPAN);
        shoulder = left > right ? left : right;
        return 2 * v - shoulder >= 2 * int'(cfg.prominence_threshold);
    endfunction

    function automatic void advance_bin(int c, int n, bit lookahead, bit last);
        int                 lvl, w, s, g, ahold, rhold;
        bit                 qual, arm_ev, rel_ev;
        sgard_pkg::result_t r;
        lvl = level_at(n, c);
        w = cfg.smoothing_weight > sgard_pkg::WEIGHT_ONE ? 256 : int'(cfg.smoothing_weight);
        s = w * (lvl - int'(prev_level[c])) + (256 - w) * int'(growth_mem[c]);
        g = (s + 128) >>> 8;
        if (g > 32767)
            g = 32767;
        if (g < -32768)
            g = -32768;
        ahold = cfg.arm_hold_count == 0 ? 1 : int'(cfg.arm_hold_count);
        rhold = cfg.release_hold_count == 0 ? 1 : int'(cfg.release_hold_count);
        qual = lookahead && peak_found(c, n) && lvl > int'(cfg.silence_floor)
               && g >= int'(cfg.arm_growth_threshold);
        arm_ev = 1'b0;
        rel_ev = 1'b0;
        growth_mem[c] = g[15:0];
        if (qual)
        begin
            if (qual_cnt[c] < sgard_pkg::COUNT_MAX)
                qual_cnt[c] = qual_cnt[c] + 1;
        end
        else
            qual_cnt[c] = '0;
        if (!armed_mem[c] && int'(qual_cnt[c]) >= ahold)
        begin
            armed_mem[c] = 1'b1;
            peak_mem[c] = lvl[15:0];
            below_cnt[c] = '0;
            armed_now = armed_now + 1;
            arms_seen = arms_seen + 1;
            arm_ev = 1'b1;
        end
        else if (armed_mem[c])
        begin
            if (lvl > int'(peak_mem[c]))
                peak_mem[c] = lvl[15:0];
            if (lvl <= int'(peak_mem[c]) - int'(cfg.release_margin))
            begin
                if (below_cnt[c] < sgard_pkg::COUNT_MAX)
                    below_cnt[c] = below_cnt[c] + 1;
            end
            else
                below_cnt[c] = '0;
            if (int'(below_cnt[c]) >= rhold)
            begin
                armed_mem[c] = 1'b0;
                qual_cnt[c] = '0;
                armed_now = armed_now - 1;
                releases_seen = releases_seen + 1;
                rel_ev = 1'b1;
            end
        end
        prev_level[c] = lvl[15:0];
        r.bin_number = c[10:0];
        r.growth_now = g[15:0];
        r.bin_armed = armed_mem[c];
        r.armed_event = arm_ev;
        r.released_event = rel_ev;
        r.armed_bins = armed_now;
        r.arm_total = arms_seen;
        r.release_total = releases_seen;
        r.last_of_frame = last;
        results_due.push_back(r);
    endfunction

    function automatic void take_level(logic signed [15:0] lvl, logic fe);
        int n, first;
        bit fin;
        n = bin_pos;
        fin = fe || n >= NUM_BINS - 1;
        for (int i = 0; i < WIN - 1; i++)
            window[i] = window[i + 1];
        window[WIN - 1] = int'(lvl);
        if (n >= SPAN)
            advance_bin(n - SPAN, n, 1'b1, 1'b0);
        if (fin)
        begin
            first = n >= SPAN ? n - SPAN + 1 : 0;
            for (int c = first; c <= n; c++)
                advance_bin(c, n, 1'b0, c == n);
            bin_pos = 0;
        end
        else
            bin_pos = n + 1;
    endfunction

    task automatic report(string field, longint got, longint want);
        errors++;
        if (errors <= 30)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    always @(posedge clk)
    begin
        sgard_pkg::result_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                    report("unexpected result, bin_number", bin_number, -1);
                else
                begin
                    e = results_due.pop_front();
                    if (bin_number !== e.bin_number)
                        report("bin_number", bin_number, e.bin_number);
                    if (growth_now !== e.growth_now)
                        report("growth_now", growth_now, e.growth_now);
                    if (bin_armed !== e.bin_armed)
                        report("bin_armed", bin_armed, e.bin_armed);
                    if (armed_event !== e.armed_event)
                        report("armed_event", armed_event, e.armed_event);
                    if (released_event !== e.released_event)
                        report("released_event", released_event, e.released_event);
                    if (armed_bins !== e.armed_bins)
                        report("armed_bins", armed_bins, e.armed_bins);
                    if (arm_total !== e.arm_total)
                        report("arm_total", arm_total, e.arm_total);
                    if (release_total !== e.release_total)
                        report("release_total", release_total, e.release_total);
                    if (last_of_frame !== e.last_of_frame)
                        report("last_of_frame", last_of_frame, e.last_of_frame);
                end
            end
            if (push && !full)
                take_level(level_db, frame_end);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sgard_pkg::REG_PROMINENCE: cfg.prominence_threshold = cfg_data[14:0];
                    sgard_pkg::REG_ARM_GROWTH: cfg.arm_growth_threshold = cfg_data;
                    sgard_pkg::REG_RELEASE:    cfg.release_margin = cfg_data[14:0];
                    sgard_pkg::REG_FLOOR:      cfg.silence_floor = cfg_data;
                    sgard_pkg::REG_ARM_HOLD:   cfg.arm_hold_count = cfg_data[3:0];
                    sgard_pkg::REG_REL_HOLD:   cfg.release_hold_count = cfg_data[3:0];
                    sgard_pkg::REG_WEIGHT:     cfg.smoothing_weight = cfg_data[8:0];
                    default: ;
                endcase
            end
            outstanding = results_due.size();
        end
    end
endmodule

// File: tb/testbench.sv
// Top of the detector testbench: clock, reset, stimulus, idling and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN = 24;
    localparam int CYCLE_LIMIT = 40000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] level_db;
    logic               frame_end;
    logic               empty;
    logic               pop;
    logic [10:0]        bin_number;
    logic signed [15:0] growth_now;
    logic               bin_armed;
    logic               armed_event;
    logic               released_event;
    logic [10:0]        armed_bins;
    logic [31:0]        arm_total;
    logic [31:0]        release_total;
    logic               last_of_frame;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    int                 errors;
    int                 outstanding;
    int                 cycles;
    bit                 steady;
    bit                 hold_request;
    int                 tone [FRAME_LEN];

    spectral_growth_arm_release_detector_top i_dut (.*);

    growth_detector_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (400) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (steady)
                pop <= 1'b1;
            else
                pop <= $urandom_range(0, 99) >= 10;
        end
    end

    task automatic send_level(logic signed [15:0] lvl, logic fe);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        level_db <= lvl;
        frame_end <= fe;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic quiesce();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic tone_frame();
        for (int b = 0; b < FRAME_LEN; b++)
        begin
            if (b == 8 || b == 14)
            begin
                if ($urandom_range(0, 5) == 0)
                    tone[b] = tone[b] - 4000;
                else
                    tone[b] = tone[b] + $urandom_range(0, 900);
                if (tone[b] > 30000)
                    tone[b] = 30000;
                if (tone[b] < -12000)
                    tone[b] = -12000;
                send_level(16'(tone[b]), b == FRAME_LEN - 1);
            end
            else
                send_level(16'(-8000 + int'($urandom_range(0, 400))), b == FRAME_LEN - 1);
        end
    endtask

    task automatic noise_frame();
        int len;
        len = $urandom_range(1, 30);
        for (int b = 0; b < len; b++)
            send_level(16'($urandom), b == len - 1 || $urandom_range(0, 7) == 0);
    endtask

    task automatic run_frames(int frames);
        for (int f = 0; f < frames; f++)
        begin
            if ($urandom_range(0, 5) == 0)
                noise_frame();
            else
                tone_frame();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        level_db = '0;
        frame_end = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sgard_pkg::REG_PROMINENCE;
        cfg_data = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        for (int i = 0; i < FRAME_LEN; i++)
            tone[i] = -8000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int b = 0; b < 17; b++)
        begin
            case (b)
                0:       send_level(16'sh7fff, 1'b0);
                1:       send_level(-16'sh8000, 1'b0);
                2:       send_level(16'sh5555, 1'b0);
                3:       send_level(16'shaaaa, 1'b0);
                8:       send_level(16'sd20000, 1'b0);
                16:      send_level(-16'sd6000, 1'b1);
                default: send_level(-16'sd6000, 1'b0);
            endcase
        end
        send_level(16'sd100, 1'b0);
        send_level(16'sd200, 1'b0);
        send_level(16'sd300, 1'b1);
        send_level(-16'sd1, 1'b1);

        run_frames(1);
        quiesce();

        write_reg(sgard_pkg::REG_PROMINENCE, 16'd0);
        write_reg(sgard_pkg::REG_ARM_GROWTH, 16'h8000);
        write_reg(sgard_pkg::REG_RELEASE, 16'd0);
        write_reg(sgard_pkg::REG_FLOOR, 16'h8000);
        write_reg(sgard_pkg::REG_ARM_HOLD, 16'd1);
        write_reg(sgard_pkg::REG_REL_HOLD, 16'd1);
        write_reg(sgard_pkg::REG_WEIGHT, 16'd256);
        hold_request = 1'b1;
        run_frames(1);
        steady = 1'b1;
        run_frames(1);
        steady = 1'b0;
        quiesce();

        write_reg(sgard_pkg::REG_PROMINENCE, 16'h7fff);
        write_reg(sgard_pkg::REG_ARM_GROWTH, 16'h7fff);
        write_reg(sgard_pkg::REG_RELEASE, 16'h7fff);
        write_reg(sgard_pkg::REG_FLOOR, 16'h7fff);
        write_reg(sgard_pkg::REG_ARM_HOLD, 16'd15);
        write_reg(sgard_pkg::REG_REL_HOLD, 16'd15);
        write_reg(sgard_pkg::REG_WEIGHT, 16'd0);
        run_frames(1);
        quiesce();

        write_reg(sgard_pkg::REG_PROMINENCE, 16'd1600);
        write_reg(sgard_pkg::REG_ARM_GROWTH, 16'd0);
        write_reg(sgard_pkg::REG_RELEASE, 16'd640);
        write_reg(sgard_pkg::REG_FLOOR, -16'sd20000);
        write_reg(sgard_pkg::REG_ARM_HOLD, 16'd0);
        write_reg(sgard_pkg::REG_REL_HOLD, 16'd0);
        write_reg(sgard_pkg::REG_WEIGHT, 16'd511);
        run_frames(1);
        quiesce();

        write_reg(sgard_pkg::REG_PROMINENCE, 16'($urandom_range(0, 6000)));
        write_reg(sgard_pkg::REG_ARM_GROWTH, 16'($urandom_range(0, 400)));
        write_reg(sgard_pkg::REG_RELEASE, 16'($urandom_range(0, 5000)));
        write_reg(sgard_pkg::REG_FLOOR, -16'sd15000);
        write_reg(sgard_pkg::REG_ARM_HOLD, 16'($urandom_range(1, 4)));
        write_reg(sgard_pkg::REG_REL_HOLD, 16'($urandom_range(1, 4)));
        write_reg(sgard_pkg::REG_WEIGHT, 16'($urandom_range(0, 511)));
        run_frames(1);
        quiesce();

        if (errors == 0 && outstanding == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
